// ===== sv/velocity_smoothstep_gain_curve_unit_defines.svh =====
// Assertion macros shared by the checker of the velocity gain curve unit.
`ifndef VELOCITY_SMOOTHSTEP_GAIN_CURVE_UNIT_DEFINES_SVH
`define VELOCITY_SMOOTHSTEP_GAIN_CURVE_UNIT_DEFINES_SVH

// Implication in the same cycle, ignored while reset is high.
`define VSGC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vsgc check failed");

// Implication into the next cycle, ignored while reset is high.
`define VSGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vsgc check failed");

// Implication in the same cycle that also holds across reset.
`define VSGC_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("vsgc check failed");

`endif

// ===== sv/vsgc_pkg.sv =====
// Shared types, constants and preset tables of the velocity gain curve unit.
`default_nettype none
package vsgc_pkg;

   localparam int VALUE_W             = 16;
   localparam int CSR_INDEX_W         = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int DIV_STEPS           = 16;

   localparam logic [VALUE_W-1:0] GAIN_ONE     = 16'd16384;
   localparam logic [17:0]        SMOOTH_THREE = 18'd196608;
   localparam logic [31:0]        ROUND_HALF   = 32'd32768;

   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_PRESET   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_GAIN       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MID_GAIN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_GAIN      = 3'd5;

   typedef enum logic [2:0] {
      PRESET_LINEAR   = 3'd0,
      PRESET_S_CURVE  = 3'd1,
      PRESET_ONE_TAP  = 3'd2,
      PRESET_RED_ZONE = 3'd3,
      PRESET_CUSTOM   = 3'd4
   } preset_type;

   typedef struct packed {
      logic [VALUE_W-1:0] lo_thr;
      logic [VALUE_W-1:0] hi_thr;
      logic [VALUE_W-1:0] g_lo;
      logic [VALUE_W-1:0] g_mid;
      logic [VALUE_W-1:0] g_hi;
   } curve_type;

   typedef enum logic {
      KIND_DIRECT = 1'b0,
      KIND_BLEND  = 1'b1
   } entry_kind_type;

   // A direct entry carries its finished gain in g_lo.
   typedef struct packed {
      entry_kind_type     kind;
      logic [VALUE_W-1:0] num;
      logic [VALUE_W-1:0] den;
      logic [VALUE_W-1:0] g_lo;
      logic [VALUE_W-1:0] g_mid;
      logic [VALUE_W-1:0] g_hi;
   } queue_entry_type;

   typedef enum logic [2:0] {
      B_IDLE   = 3'd0,
      B_DIVIDE = 3'd1,
      B_SQUARE = 3'd2,
      B_CUBE   = 3'd3,
      B_SCALE  = 3'd4,
      B_EMIT   = 3'd5
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic load_div;
      logic div_step;
      logic do_square;
      logic do_cube;
      logic do_scale;
      logic emit_direct;
      logic emit_blend;
   } back_ctrl_type;

   function automatic curve_type builtin_curve(input preset_type preset);
      curve_type c;
      case (preset)
         PRESET_S_CURVE:  c = '{16'd77,  16'd1024, 16'd13926, 16'd16384, 16'd18842};
         PRESET_ONE_TAP:  c = '{16'd51,  16'd768,  16'd11469, 16'd15565, 16'd18022};
         PRESET_RED_ZONE: c = '{16'd128, 16'd1536, 16'd14746, 16'd16384, 16'd21299};
         default:         c = '{16'd0,   16'd0,    GAIN_ONE,  GAIN_ONE,  GAIN_ONE};
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/vsgc_front.sv =====
// Front end: holds the configuration registers and classifies each velocity beat.
`default_nettype none
module vsgc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [vsgc_pkg::VALUE_W-1:0]        req_velocity,
   input  logic                                csr_we,
   input  logic [vsgc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vsgc_pkg::VALUE_W-1:0]        csr_wdata,
   input  logic                                q_full,
   output logic                                q_push,
   output vsgc_pkg::queue_entry_type           q_entry
);
   import vsgc_pkg::*;

   preset_type         preset_ff;
   logic [VALUE_W-1:0] lo_thr_ff;
   logic [VALUE_W-1:0] hi_thr_ff;
   logic [VALUE_W-1:0] g_lo_ff;
   logic [VALUE_W-1:0] g_mid_ff;
   logic [VALUE_W-1:0] g_hi_ff;
   curve_type          curve;
   logic               linear;

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff <= PRESET_LINEAR;
         lo_thr_ff <= 16'd128;
         hi_thr_ff <= 16'd1280;
         g_lo_ff   <= GAIN_ONE;
         g_mid_ff  <= GAIN_ONE;
         g_hi_ff   <= GAIN_ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CURVE_PRESET:   preset_ff <= preset_type'(csr_wdata[2:0]);
            CSR_LOW_THRESHOLD:  lo_thr_ff <= csr_wdata;
            CSR_HIGH_THRESHOLD: hi_thr_ff <= csr_wdata;
            CSR_LOW_GAIN:       g_lo_ff   <= csr_wdata;
            CSR_MID_GAIN:       g_mid_ff  <= csr_wdata;
            CSR_HIGH_GAIN:      g_hi_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      linear = 1'b0;
      case (preset_ff)
         PRESET_S_CURVE, PRESET_ONE_TAP, PRESET_RED_ZONE: curve = builtin_curve(preset_ff);
         PRESET_CUSTOM: curve = '{lo_thr_ff, hi_thr_ff, g_lo_ff, g_mid_ff, g_hi_ff};
         default: begin
            curve  = builtin_curve(PRESET_LINEAR);
            linear = 1'b1;
         end
      endcase
   end

   always_comb begin
      q_entry.num   = req_velocity - curve.lo_thr;
      q_entry.den   = curve.hi_thr - curve.lo_thr;
      q_entry.g_mid = curve.g_mid;
      q_entry.g_hi  = curve.g_hi;
      q_entry.kind  = KIND_DIRECT;
      if (linear) begin
         q_entry.g_lo = GAIN_ONE;
      end else if (req_velocity <= curve.lo_thr) begin
         q_entry.g_lo = curve.g_lo;
      end else if (req_velocity >= curve.hi_thr) begin
         q_entry.g_lo = curve.g_hi;
      end else begin
         q_entry.g_lo = curve.g_lo;
         q_entry.kind = KIND_BLEND;
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule
`default_nettype wire

// ===== sv/vsgc_queue.sv =====
// Small FIFO of classified entries between the front end and the back end.
`default_nettype none
module vsgc_queue #(
   parameter int DEPTH = vsgc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vsgc_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output vsgc_pkg::queue_entry_type  head,
   output logic                       full,
   output logic                       empty
);
   import vsgc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== sv/vsgc_back.sv =====
// Back end: radix-2 divider, smoothstep multiplies, gain blend and output register.
`default_nettype none
module vsgc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  vsgc_pkg::queue_entry_type       q_head,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vsgc_pkg::VALUE_W-1:0]    rsp_gain
);
   import vsgc_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   back_state_type     state_ff;
   back_state_type     state_in;
   back_ctrl_type      ctrl;
   logic [CNT_W-1:0]   cnt_ff;
   logic [VALUE_W-1:0] rem_ff;
   logic [VALUE_W-1:0] quo_ff;
   logic [VALUE_W-1:0] den_ff;
   logic [VALUE_W-1:0] g_lo_ff;
   logic [VALUE_W-1:0] g_mid_ff;
   logic [VALUE_W-1:0] g_hi_ff;
   logic [VALUE_W-1:0] ga_ff;
   logic [VALUE_W-1:0] gb_ff;
   logic [31:0]        sq_ff;
   logic [17:0]        term_ff;
   logic [VALUE_W-1:0] s_ff;
   logic [31:0]        mix_ff;
   logic               up_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_gain_ff;

   logic               out_free;
   logic [VALUE_W:0]   shifted;
   logic               fits;
   logic [VALUE_W-1:0] u;
   logic [31:0]        sq_in;
   logic [17:0]        term_in;
   logic [49:0]        prod;
   logic [VALUE_W-1:0] diff;
   logic [32:0]        rounded;
   logic [VALUE_W-1:0] part;
   logic [VALUE_W-1:0] blend_gain;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && q_head.kind == KIND_BLEND) begin
               state_in = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = B_SQUARE;
            end
         end
         B_SQUARE: state_in = B_CUBE;
         B_CUBE:   state_in = B_SCALE;
         B_SCALE:  state_in = B_EMIT;
         B_EMIT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (q_head.kind == KIND_BLEND) begin
                  ctrl.pop      = 1'b1;
                  ctrl.load_div = 1'b1;
               end else if (out_free) begin
                  ctrl.pop         = 1'b1;
                  ctrl.emit_direct = 1'b1;
               end
            end
         end
         B_DIVIDE: ctrl.div_step  = 1'b1;
         B_SQUARE: ctrl.do_square = 1'b1;
         B_CUBE:   ctrl.do_cube   = 1'b1;
         B_SCALE:  ctrl.do_scale  = 1'b1;
         B_EMIT:   ctrl.emit_blend = out_free;
         default: ;
      endcase
   end

   assign q_pop = ctrl.pop;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = (shifted >= {1'b0, den_ff});
      u       = {quo_ff[VALUE_W-2:0], 1'b0};
      sq_in   = 32'(u) * 32'(u);
      term_in = SMOOTH_THREE - 18'({u, 1'b0});
      prod    = 50'(sq_ff) * 50'(term_ff);
      diff    = (gb_ff >= ga_ff) ? gb_ff - ga_ff : ga_ff - gb_ff;
      rounded = {1'b0, mix_ff} + {1'b0, ROUND_HALF};
      part    = rounded[31:16];
      blend_gain = up_ff ? ga_ff + part : ga_ff - part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_div) begin
         rem_ff   <= q_head.num;
         quo_ff   <= '0;
         den_ff   <= q_head.den;
         g_lo_ff  <= q_head.g_lo;
         g_mid_ff <= q_head.g_mid;
         g_hi_ff  <= q_head.g_hi;
         cnt_ff   <= '0;
      end
      if (ctrl.div_step) begin
         rem_ff <= fits ? VALUE_W'(shifted - {1'b0, den_ff}) : shifted[VALUE_W-1:0];
         quo_ff <= {quo_ff[VALUE_W-2:0], fits};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (ctrl.do_square) begin
         sq_ff   <= sq_in;
         term_ff <= term_in;
         ga_ff   <= quo_ff[VALUE_W-1] ? g_mid_ff : g_lo_ff;
         gb_ff   <= quo_ff[VALUE_W-1] ? g_hi_ff : g_mid_ff;
      end
      if (ctrl.do_cube) begin
         s_ff <= prod[47:32];
      end
      if (ctrl.do_scale) begin
         mix_ff <= 32'(diff) * 32'(s_ff);
         up_ff  <= (gb_ff >= ga_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit_direct || ctrl.emit_blend) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_direct) begin
         rsp_gain_ff <= q_head.g_lo;
      end else if (ctrl.emit_blend) begin
         rsp_gain_ff <= blend_gain;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gain  = rsp_gain_ff;

endmodule
`default_nettype wire

// ===== sv/velocity_smoothstep_gain_curve_unit.sv =====
// Top level of the velocity gain curve unit.
// Each velocity beat yields one Q2.14 gain beat, in order. The front end takes a
// velocity every cycle while its entry queue has room and decides at once whether
// the gain is a fixed value (linear preset, at or below the low threshold, at or
// above the high threshold) or needs a blend. A fixed-value beat is popped and
// written out once the back end is idle and the output register is free; a
// blended beat holds the back end through a load step, the bit-serial restoring
// divide that forms the normalized position, the squaring, cubic and scaling
// multiplies, and a step that rounds and writes the output register. Fixed values
// sustain one beat per cycle while each gain is accepted; the back end takes no
// new beat until a blend is written out. Configuration writes take effect at once
// and must be made while no beat is in flight.
`default_nettype none
module velocity_smoothstep_gain_curve_unit #(
   parameter int QUEUE_DEPTH = vsgc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vsgc_pkg::VALUE_W-1:0]      req_velocity,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vsgc_pkg::VALUE_W-1:0]      rsp_gain,
   input  logic                              csr_we,
   input  logic [vsgc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vsgc_pkg::VALUE_W-1:0]      csr_wdata
);
   import vsgc_pkg::*;

   queue_entry_type push_entry;
   queue_entry_type head;
   logic            q_push;
   logic            q_pop;
   logic            q_full;
   logic            q_empty;

   vsgc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_velocity (req_velocity),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (push_entry)
   );

   vsgc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   vsgc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_gain  (rsp_gain)
   );

endmodule
`default_nettype wire

// ===== sv/vsgc_checker.sv =====
// Port-level checker of the velocity gain curve unit and its bind.
`default_nettype none
`include "velocity_smoothstep_gain_curve_unit_defines.svh"
module vsgc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [vsgc_pkg::VALUE_W-1:0]      rsp_gain,
   input logic                              csr_we,
   input logic [vsgc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [vsgc_pkg::VALUE_W-1:0]      csr_wdata
);
   import vsgc_pkg::*;

   logic [7:0] pending_ff;
   logic [2:0] preset_ff;
   logic       in_beat;
   logic       out_beat;
   logic       linear;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;
   assign linear   = (preset_ff != PRESET_S_CURVE) && (preset_ff != PRESET_ONE_TAP) &&
                     (preset_ff != PRESET_RED_ZONE) && (preset_ff != PRESET_CUSTOM);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         preset_ff  <= PRESET_LINEAR;
      end else begin
         pending_ff <= pending_ff + {7'd0, in_beat} - {7'd0, out_beat};
         if (csr_we && csr_index == CSR_CURVE_PRESET) begin
            preset_ff <= csr_wdata[2:0];
         end
      end
   end

   `VSGC_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_gain))
   `VSGC_ASSERT_ALWAYS(rsp_quiet_after_reset, $past(reset), !rsp_valid)
   `VSGC_ASSERT_NOW(rsp_has_source, rsp_valid, pending_ff != 8'd0)
   `VSGC_ASSERT_NOW(linear_unity, rsp_valid && linear, rsp_gain == GAIN_ONE)

endmodule

bind velocity_smoothstep_gain_curve_unit vsgc_checker u_vsgc_checker (.*);
`default_nettype wire

// ===== tb/sv/velocity_smoothstep_gain_curve_unit_tb.sv =====
// Self-checking testbench of the velocity gain curve unit with its own gain predictor.
`default_nettype none
module velocity_smoothstep_gain_curve_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vsgc_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int STALL_LIMIT  = 4000;
   localparam int PRINT_LIMIT  = 200;
   localparam int SETTLE_WAIT  = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam logic [2:0] PRESET_SPARE_LO  = 3'd5;
   localparam logic [2:0] PRESET_SPARE_MID = 3'd6;
   localparam logic [2:0] PRESET_SPARE_HI  = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_W-1:0]     req_velocity;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VALUE_W-1:0]     rsp_gain;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [VALUE_W-1:0]     csr_wdata;

   logic [2:0]         cfg_preset;
   logic [VALUE_W-1:0] cfg_low_thr;
   logic [VALUE_W-1:0] cfg_high_thr;
   logic [VALUE_W-1:0] cfg_low_gain;
   logic [VALUE_W-1:0] cfg_mid_gain;
   logic [VALUE_W-1:0] cfg_high_gain;

   logic [VALUE_W-1:0] pending_gains[$];
   logic [VALUE_W-1:0] oldest_gain;
   int unsigned        mismatch_count;
   int unsigned        quiet_cycles;
   int unsigned        sender_idle_pct;
   int unsigned        receiver_stall_pct;

   velocity_smoothstep_gain_curve_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_velocity (req_velocity),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gain     (rsp_gain),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic curve_type current_curve();
      curve_type c;
      case (cfg_preset)
         PRESET_S_CURVE:  c = '{16'd77,  16'd1024, 16'd13926, 16'd16384, 16'd18842};
         PRESET_ONE_TAP:  c = '{16'd51,  16'd768,  16'd11469, 16'd15565, 16'd18022};
         PRESET_RED_ZONE: c = '{16'd128, 16'd1536, 16'd14746, 16'd16384, 16'd21299};
         PRESET_CUSTOM:   c = '{cfg_low_thr, cfg_high_thr, cfg_low_gain, cfg_mid_gain,
                                cfg_high_gain};
         default:         c = '{16'd0, 16'hFFFF, GAIN_ONE, GAIN_ONE, GAIN_ONE};
      endcase
      return c;
   endfunction

   function automatic logic [VALUE_W-1:0] curve_gain(input logic [VALUE_W-1:0] velocity);
      curve_type c;
      bit [63:0] span;
      bit [63:0] pos;
      bit [63:0] u;
      bit [63:0] s;
      bit [63:0] a;
      bit [63:0] b;
      bit [63:0] part;
      if (cfg_preset < PRESET_S_CURVE || cfg_preset > PRESET_CUSTOM) begin
         return GAIN_ONE;
      end
      c = current_curve();
      if (velocity <= c.lo_thr) begin
         return c.g_lo;
      end
      if (velocity >= c.hi_thr) begin
         return c.g_hi;
      end
      span = 64'(c.hi_thr - c.lo_thr);
      pos  = (64'(velocity - c.lo_thr) << 16) / span;
      if (pos < 64'd32768) begin
         u = pos * 2;
         a = 64'(c.g_lo);
         b = 64'(c.g_mid);
      end else begin
         u = (pos - 64'd32768) * 2;
         a = 64'(c.g_mid);
         b = 64'(c.g_hi);
      end
      s = (u * u * (64'd196608 - 2 * u)) >> 32;
      if (b >= a) begin
         part = ((b - a) * s + 64'd32768) >> 16;
         return 16'(a + part);
      end
      part = ((a - b) * s + 64'd32768) >> 16;
      return 16'(a - part);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_velocity();
      curve_type          c;
      int unsigned        roll;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      c    = current_curve();
      roll = $urandom_range(0, 99);
      lo   = (c.lo_thr < c.hi_thr) ? c.lo_thr : c.hi_thr;
      hi   = (c.lo_thr < c.hi_thr) ? c.hi_thr : c.lo_thr;
      if (roll < 20) begin
         return 16'($urandom_range(0, 65535));
      end
      if (roll < 35) begin
         return 16'(((roll % 2 == 0) ? c.lo_thr : c.hi_thr) + $urandom_range(0, 4) - 2);
      end
      return 16'($urandom_range(lo, hi));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [VALUE_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_CURVE_PRESET:   cfg_preset    = data[2:0];
         CSR_LOW_THRESHOLD:  cfg_low_thr   = data;
         CSR_HIGH_THRESHOLD: cfg_high_thr  = data;
         CSR_LOW_GAIN:       cfg_low_gain  = data;
         CSR_MID_GAIN:       cfg_mid_gain  = data;
         CSR_HIGH_GAIN:      cfg_high_gain = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_velocity(input logic [VALUE_W-1:0] velocity);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_velocity <= velocity;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_gains.push_back(curve_gain(velocity));
      @(negedge clock);
   endtask

   task automatic finish_gains();
      req_valid <= 1'b0;
      while (pending_gains.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic set_custom_curve(input logic [VALUE_W-1:0] lo_thr,
                                   input logic [VALUE_W-1:0] hi_thr,
                                   input logic [VALUE_W-1:0] g_lo,
                                   input logic [VALUE_W-1:0] g_mid,
                                   input logic [VALUE_W-1:0] g_hi);
      write_csr(CSR_LOW_THRESHOLD, lo_thr);
      write_csr(CSR_HIGH_THRESHOLD, hi_thr);
      write_csr(CSR_LOW_GAIN, g_lo);
      write_csr(CSR_MID_GAIN, g_mid);
      write_csr(CSR_HIGH_GAIN, g_hi);
   endtask

   function automatic logic [VALUE_W-1:0] pick_gain();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         return 16'd0;
      end
      if (roll < 30) begin
         return 16'hFFFF;
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic randomize_curve();
      int unsigned        roll;
      logic [2:0]         preset;
      logic [VALUE_W-1:0] lo_thr;
      logic [VALUE_W-1:0] hi_thr;
      finish_gains();
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         preset = PRESET_CUSTOM;
      end else if (roll < 85) begin
         preset = 3'($urandom_range(PRESET_S_CURVE, PRESET_RED_ZONE));
      end else begin
         case ($urandom_range(0, 3))
            0:       preset = PRESET_LINEAR;
            1:       preset = PRESET_SPARE_LO;
            2:       preset = PRESET_SPARE_MID;
            default: preset = PRESET_SPARE_HI;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         hi_thr = 16'($urandom_range(0, 65535));
         lo_thr = 16'($urandom_range(hi_thr, 65535));
      end else if (roll < 25) begin
         lo_thr = 16'($urandom_range(0, 65532));
         hi_thr = 16'(lo_thr + $urandom_range(1, 3));
      end else begin
         lo_thr = 16'($urandom_range(0, 40000));
         hi_thr = 16'($urandom_range(lo_thr + 4, 65535));
      end
      set_custom_curve(lo_thr, hi_thr, pick_gain(), pick_gain(), pick_gain());
      if ($urandom_range(0, 99) < 30) begin
         write_csr(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                   16'($urandom_range(0, 65535)));
      end
      write_csr(CSR_CURVE_PRESET, {13'($urandom_range(0, 8191)), preset});
   endtask

   task automatic test_reset_defaults();
      send_velocity(16'd0);
      send_velocity(16'hFFFF);
      finish_gains();
   endtask

   task automatic test_linear_and_spare_presets();
      write_csr(CSR_CURVE_PRESET, {13'h1FFF, PRESET_SPARE_HI});
      send_velocity(16'd300);
      finish_gains();
      write_csr(CSR_CURVE_PRESET, {13'h1FFF, PRESET_SPARE_LO});
      send_velocity(16'h8000);
      finish_gains();
      write_csr(CSR_CURVE_PRESET, {13'h0000, PRESET_SPARE_MID});
      send_velocity(16'd1);
      finish_gains();
   endtask

   task automatic test_builtin_presets();
      curve_type c;
      for (int p = PRESET_S_CURVE; p <= PRESET_RED_ZONE; p++) begin
         write_csr(CSR_CURVE_PRESET, {13'h0000, 3'(p)});
         c = current_curve();
         send_velocity(c.lo_thr);
         send_velocity(16'((c.lo_thr + c.hi_thr) / 2));
         send_velocity(16'(c.hi_thr - 1));
         finish_gains();
      end
   endtask

   task automatic test_custom_extremes();
      write_csr(CSR_CURVE_PRESET, {13'h0000, PRESET_CUSTOM});
      set_custom_curve(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      send_velocity(16'd0);
      send_velocity(16'd1);
      send_velocity(16'h8000);
      send_velocity(16'hFFFE);
      send_velocity(16'hFFFF);
      finish_gains();
      // Writes to the spare register indexes must leave every register alone.
      write_csr(CSR_SPARE_A, 16'h0000);
      write_csr(CSR_SPARE_B, 16'hFFFF);
      send_velocity(16'h4000);
      finish_gains();
      // Crossed thresholds: the low test wins, everything else takes the high gain.
      set_custom_curve(16'd1000, 16'd500, 16'd1000, 16'd20000, 16'd30000);
      send_velocity(16'd700);
      send_velocity(16'd1000);
      send_velocity(16'd1001);
      finish_gains();
      write_csr(CSR_HIGH_THRESHOLD, 16'd1000);
      send_velocity(16'd1001);
      finish_gains();
   endtask

   task automatic test_random_traffic();
      int unsigned sender_pcts[4]   = '{0, 66, 0, 24};
      int unsigned receiver_pcts[4] = '{0, 0, 66, 24};
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_pcts[phase];
         receiver_stall_pct = receiver_pcts[phase];
         for (int setting = 0; setting < 6; setting++) begin
            randomize_curve();
            repeat (77) begin
               send_velocity(pick_velocity());
               if ($urandom_range(0, 63) == 0) begin
                  finish_gains();
               end
            end
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_gains.size() == 0) begin
            report_mismatch("gain beat with nothing pending", rsp_gain, 0);
         end else begin
            oldest_gain = pending_gains.pop_front();
            if (rsp_gain !== oldest_gain) begin
               report_mismatch("gain", rsp_gain, oldest_gain);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved in %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_velocity       = '0;
      rsp_ready          = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      cfg_preset         = PRESET_LINEAR;
      cfg_low_thr        = 16'd128;
      cfg_high_thr       = 16'd1280;
      cfg_low_gain       = GAIN_ONE;
      cfg_mid_gain       = GAIN_ONE;
      cfg_high_gain      = GAIN_ONE;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_linear_and_spare_presets();
      test_builtin_presets();
      test_custom_extremes();
      test_random_traffic();

      finish_gains();
      repeat (SETTLE_WAIT) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
